// ----- sv/mdw_pkg.sv -----
// ----------------------------------------------------------------------------
// mdw_pkg
// Shared types and constants for the multiword divide-by-word block.
// ----------------------------------------------------------------------------
package mdw_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FIELD_BITS    = 32;

  localparam logic [FIELD_BITS-1:0] DIVISOR_RESET = FIELD_BITS'(1);

  typedef struct packed {
    logic [FIELD_BITS-1:0] dividend_word;
    logic                  last_word;
  } in_beat_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] quotient_word;
    logic [FIELD_BITS-1:0] final_remainder;
    logic                  is_last;
    logic                  divide_error;
  } out_beat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PRE,
    S_MAIN,
    S_WRITE
  } state_t;

endpackage

// ----- sv/multiword_divide_by_word.sv -----
// ----------------------------------------------------------------------------
// multiword_divide_by_word
// Short division of a multiword unsigned number by one configured word.
// ----------------------------------------------------------------------------
// Words arrive most significant first; each beat returns one quotient word,
// and the beat marked last also returns the final remainder and clears the
// carried remainder. One shared radix-2 divider produces one quotient bit
// per cycle, and a new word is accepted only once the previous one has
// reached the output register. If the carried remainder is not below the
// divisor (divisor rewritten in mid number) the divider first reduces it
// in a separate pass. A zero divisor gives an error beat without starting
// the divider. A finished beat waits in the output register, and a new
// word may be accepted while it waits.
module multiword_divide_by_word #(
  parameter int WORD_BITS = mdw_pkg::WORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [mdw_pkg::FIELD_BITS-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  mdw_pkg::in_beat_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output mdw_pkg::out_beat_t        out_data
);
  import mdw_pkg::*;

  state_t                state;
  state_t                state_next;
  logic [FIELD_BITS-1:0] divisor;
  logic [WORD_BITS-1:0]  rr;
  logic [WORD_BITS-1:0]  word;
  logic                  last;
  logic                  err;
  out_beat_t             out_reg;
  logic                  out_valid_reg;

  logic [WORD_BITS-1:0]  d;
  logic [WORD_BITS-1:0]  in_word;
  logic                  in_fire;
  logic                  d_zero;
  logic                  need_pre;
  logic                  out_load;
  logic                  div_start;
  logic [WORD_BITS-1:0]  div_rem_in;
  logic [WORD_BITS-1:0]  div_num_in;
  logic                  div_done;
  logic [WORD_BITS-1:0]  div_quo;
  logic [WORD_BITS-1:0]  div_rem;

  assign d         = divisor[WORD_BITS-1:0];
  assign in_word   = in_data.dividend_word[WORD_BITS-1:0];
  assign d_zero    = (d == '0);
  assign need_pre  = (rr >= d);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_reg;
  assign out_data  = out_reg;

  mdw_div_unit #(
    .WORD_BITS(WORD_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .rem_in(div_rem_in),
    .num_in(div_num_in),
    .dvs_in(d),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (d_zero) begin
            state_next = S_WRITE;
          end else if (need_pre) begin
            state_next = S_PRE;
          end else begin
            state_next = S_MAIN;
          end
        end
      end
      S_PRE: begin
        if (div_done) begin
          state_next = S_MAIN;
        end
      end
      S_MAIN: begin
        if (div_done) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        if (!out_valid_reg || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready   = 1'b0;
    div_start  = 1'b0;
    div_rem_in = '0;
    div_num_in = in_word;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && !d_zero) begin
          div_start = 1'b1;
          if (need_pre) begin
            div_rem_in = '0;
            div_num_in = rr;
          end else begin
            div_rem_in = rr;
            div_num_in = in_word;
          end
        end
      end
      S_PRE: begin
        if (div_done) begin
          div_start  = 1'b1;
          div_rem_in = div_rem;
          div_num_in = word;
        end
      end
      S_WRITE: begin
        out_load = !out_valid_reg || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      divisor       <= DIVISOR_RESET;
      rr            <= '0;
      out_valid_reg <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        divisor <= cfg_data;
      end
      if (out_load) begin
        out_valid_reg <= 1'b1;
        rr            <= (err || last) ? '0 : div_rem;
      end else if (out_ready) begin
        out_valid_reg <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      word <= in_word;
      last <= in_data.last_word;
      err  <= d_zero;
    end
    if (out_load) begin
      if (err) begin
        out_reg <= '{default: '0, divide_error: 1'b1};
      end else begin
        out_reg.quotient_word   <= FIELD_BITS'(div_quo);
        out_reg.final_remainder <= last ? FIELD_BITS'(div_rem) : '0;
        out_reg.is_last         <= last;
        out_reg.divide_error    <= 1'b0;
      end
    end
  end

  a_zero_to_write: assert property (@(posedge clk) disable iff (rst)
    in_fire && d_zero |=> state == S_WRITE)
    else $error("zero divisor did not go straight to write");

  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_PRE || state == S_MAIN))
    else $error("divider finished outside a run state");

  a_main_to_write: assert property (@(posedge clk) disable iff (rst)
    div_done && state == S_MAIN |=> state == S_WRITE)
    else $error("main pass did not end in write");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.divide_error |->
      (out_data.quotient_word == '0 && out_data.final_remainder == '0 &&
       !out_data.is_last))
    else $error("error beat carries nonzero fields");

  a_rr_cleared: assert property (@(posedge clk) disable iff (rst)
    out_load && (err || last) |=> rr == '0)
    else $error("carried remainder not cleared at end of number");

endmodule

// ----- sv/mdw_div_unit.sv -----
// ----------------------------------------------------------------------------
// mdw_div_unit
// Radix-2 restoring divider: one quotient bit per cycle over a word-wide
// numerator, starting from a partial remainder that is below the divisor.
// ----------------------------------------------------------------------------
module mdw_div_unit #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] rem_in,
  input  logic [WORD_BITS-1:0] num_in,
  input  logic [WORD_BITS-1:0] dvs_in,
  output logic                 done,
  output logic [WORD_BITS-1:0] quo,
  output logic [WORD_BITS-1:0] rem
);
  import mdw_pkg::*;

  localparam int CNT_BITS = $clog2(WORD_BITS);

  logic                 busy;
  logic [CNT_BITS-1:0]  cnt;
  logic [WORD_BITS-1:0] dvs;
  logic [WORD_BITS-1:0] p;
  logic [WORD_BITS-1:0] q;
  logic [WORD_BITS:0]   trial;
  logic [WORD_BITS:0]   diff;
  logic                 ge;

  assign trial = {p, q[WORD_BITS-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = trial >= {1'b0, dvs};
  assign quo   = q;
  assign rem   = p;

  // done pulses once the last quotient bit is in
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(WORD_BITS - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= dvs_in;
      p   <= rem_in;
      q   <= num_in;
    end else if (busy) begin
      p <= ge ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
      q <= {q[WORD_BITS-2:0], ge};
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy)
    else $error("divider did not go busy after start");

  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    busy |-> (p < dvs))
    else $error("partial remainder not below divisor");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done && !start |=> !busy)
    else $error("divider still busy after last step");

endmodule
